// File: src/sspp_pkg.sv
// Shared types and constants of the sensor stream packet parser.
// Used by the interfaces, the front decoder, the queue, the back parser and the top level.
package sspp_pkg;

  localparam int unsigned RemW    = 5;
  localparam int unsigned CfgIdxW = 4;
  localparam int unsigned CfgW    = 16;

  localparam logic [CfgIdxW-1:0] CFG_IDX_CLEAN_THR = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CFG_IDX_DOCK_THR  = CfgIdxW'(1);

  localparam logic signed [15:0] CLEAN_THR_RESET = -16'sd400;
  localparam logic signed [15:0] DOCK_THR_RESET  = -16'sd50;

  localparam logic [7:0] ID_GROUP_ALL    = 8'd0;
  localparam logic [7:0] ID_GROUP_BASIC  = 8'd1;
  localparam logic [7:0] ID_BUMPS        = 8'd7;
  localparam logic [7:0] ID_VWALL        = 8'd13;
  localparam logic [7:0] ID_DISTANCE     = 8'd19;
  localparam logic [7:0] ID_CHRG_STATE   = 8'd21;
  localparam logic [7:0] ID_VOLTAGE      = 8'd22;
  localparam logic [7:0] ID_CURRENT      = 8'd23;
  localparam logic [7:0] ID_CHARGE       = 8'd25;
  localparam logic [7:0] ID_CAPACITY     = 8'd26;
  localparam logic [7:0] ID_EXT          = 8'd128;

  localparam logic [RemW-1:0] LEN_GROUP_ALL   = RemW'(26);
  localparam logic [RemW-1:0] LEN_GROUP_BASIC = RemW'(10);
  localparam logic [RemW-1:0] LEN_ONE         = RemW'(1);
  localparam logic [RemW-1:0] LEN_TWO         = RemW'(2);

  typedef enum logic [2:0] {
    KIND_SKIP,
    KIND_DIST,
    KIND_CHRG_STATE,
    KIND_VOLT,
    KIND_CURR,
    KIND_CHARGE,
    KIND_CAP
  } kind_e;

  typedef struct packed {
    logic [7:0]      data_byte;
    logic            last_byte;
    logic            known;
    kind_e           kind;
    logic [RemW-1:0] len;
  } item_t;

  typedef struct packed {
    logic               packet_ok;
    logic signed [15:0] distance_mm;
    logic [7:0]         charging_state;
    logic [15:0]        voltage_mv;
    logic signed [15:0] current_ma;
    logic signed [15:0] charge_mah;
    logic [15:0]        capacity_mah;
    logic               is_cleaning;
    logic               is_docked;
  } result_t;

endpackage

// File: src/sspp_if.sv
// Request channels of the sensor stream packet parser: byte input, result output, config write.
// Depends on sspp_pkg for widths.
interface sspp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface sspp_out_if;
  logic               valid;
  logic               ready;
  logic               packet_ok;
  logic signed [15:0] distance_mm;
  logic [7:0]         charging_state;
  logic [15:0]        voltage_mv;
  logic signed [15:0] current_ma;
  logic signed [15:0] charge_mah;
  logic [15:0]        capacity_mah;
  logic               is_cleaning;
  logic               is_docked;

  modport source (
    output valid, output packet_ok, output distance_mm, output charging_state,
    output voltage_mv, output current_ma, output charge_mah, output capacity_mah,
    output is_cleaning, output is_docked, input ready
  );
  modport sink (
    input valid, input packet_ok, input distance_mm, input charging_state,
    input voltage_mv, input current_ma, input charge_mah, input capacity_mah,
    input is_cleaning, input is_docked, output ready
  );
endinterface

interface sspp_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [sspp_pkg::CfgIdxW-1:0]  index;
  logic [sspp_pkg::CfgW-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: src/sspp_front.sv
// Front decoder: accepts input bytes and classifies each as a possible sensor ID.
// Depends on sspp_pkg and sspp_in_if; feeds sspp_fifo.
module sspp_front (
  sspp_in_if.sink         in_i,
  input  logic            full_i,
  output logic            push_o,
  output sspp_pkg::item_t item_o
);

  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i;

  always_comb begin
    item_o.data_byte = in_i.data_byte;
    item_o.last_byte = in_i.last_byte;
    item_o.known     = 1'b1;
    item_o.kind      = sspp_pkg::KIND_SKIP;
    item_o.len       = '0;
    case (in_i.data_byte)
      sspp_pkg::ID_GROUP_ALL:   item_o.len = sspp_pkg::LEN_GROUP_ALL;
      sspp_pkg::ID_GROUP_BASIC: item_o.len = sspp_pkg::LEN_GROUP_BASIC;
      sspp_pkg::ID_BUMPS,
      sspp_pkg::ID_VWALL,
      sspp_pkg::ID_EXT:         item_o.len = sspp_pkg::LEN_ONE;
      sspp_pkg::ID_CHRG_STATE: begin
        item_o.len  = sspp_pkg::LEN_ONE;
        item_o.kind = sspp_pkg::KIND_CHRG_STATE;
      end
      sspp_pkg::ID_DISTANCE: begin
        item_o.len  = sspp_pkg::LEN_TWO;
        item_o.kind = sspp_pkg::KIND_DIST;
      end
      sspp_pkg::ID_VOLTAGE: begin
        item_o.len  = sspp_pkg::LEN_TWO;
        item_o.kind = sspp_pkg::KIND_VOLT;
      end
      sspp_pkg::ID_CURRENT: begin
        item_o.len  = sspp_pkg::LEN_TWO;
        item_o.kind = sspp_pkg::KIND_CURR;
      end
      sspp_pkg::ID_CHARGE: begin
        item_o.len  = sspp_pkg::LEN_TWO;
        item_o.kind = sspp_pkg::KIND_CHARGE;
      end
      sspp_pkg::ID_CAPACITY: begin
        item_o.len  = sspp_pkg::LEN_TWO;
        item_o.kind = sspp_pkg::KIND_CAP;
      end
      default: item_o.known = 1'b0;
    endcase
  end

endmodule

// File: src/sspp_fifo.sv
// Short queue of classified bytes between the front decoder and the back parser.
// Depends on sspp_pkg for the entry type.
module sspp_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  sspp_pkg::item_t item_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output sspp_pkg::item_t item_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  sspp_pkg::item_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d;
  logic [PtrW-1:0] rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("queue count above depth");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> cnt_q != '0)
    else $error("pop from empty queue");

  a_cnt_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> cnt_q == $past(cnt_q) + CntW'(1))
    else $error("queue count lost a push");

endmodule

// File: src/sspp_back.sv
// Back parser: walks the sensor IDs and data bytes, captures values, builds the packet result.
// Depends on sspp_pkg and sspp_out_if; fed by sspp_fifo.
module sspp_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  sspp_pkg::item_t    item_i,
  output logic               pop_o,
  input  logic signed [15:0] clean_thr_i,
  input  logic signed [15:0] dock_thr_i,
  sspp_out_if.source         out_o
);

  logic [sspp_pkg::RemW-1:0] rem_q, rem_d;
  sspp_pkg::kind_e           kind_q, kind_d;
  logic [7:0]                hi_q, hi_d;
  logic                      err_q, err_d;
  logic [15:0]               dist_q, dist_d;
  logic [7:0]                chrg_q, chrg_d;
  logic [15:0]               volt_q, volt_d;
  logic [15:0]               curr_q, curr_d;
  logic [15:0]               charge_q, charge_d;
  logic [15:0]               cap_q, cap_d;
  logic                      out_valid_q, out_valid_d;
  sspp_pkg::result_t         res_q, res_d;

  logic [15:0] word;
  logic        two;
  logic        ok;
  logic        cleaning;
  logic        docked;

  assign word = {hi_q, item_i.data_byte};
  assign two  = kind_q inside {sspp_pkg::KIND_DIST, sspp_pkg::KIND_VOLT, sspp_pkg::KIND_CURR,
                               sspp_pkg::KIND_CHARGE, sspp_pkg::KIND_CAP};
  assign pop_o = valid_i && (!item_i.last_byte || !out_valid_q || out_o.ready);

  always_comb begin
    rem_d       = rem_q;
    kind_d      = kind_q;
    hi_d        = hi_q;
    err_d       = err_q;
    dist_d      = dist_q;
    chrg_d      = chrg_q;
    volt_d      = volt_q;
    curr_d      = curr_q;
    charge_d    = charge_q;
    cap_d       = cap_q;
    out_valid_d = out_valid_q && !out_o.ready;
    res_d       = res_q;
    ok          = 1'b0;
    cleaning    = 1'b0;
    docked      = 1'b0;
    if (pop_o) begin
      if (!err_q) begin
        if (rem_q == '0) begin
          kind_d = item_i.kind;
          err_d  = !item_i.known;
          rem_d  = item_i.len;
        end else begin
          if (two && rem_q == sspp_pkg::LEN_TWO) begin
            hi_d = item_i.data_byte;
          end else if (two && rem_q == sspp_pkg::LEN_ONE) begin
            case (kind_q)
              sspp_pkg::KIND_DIST:   dist_d   = word;
              sspp_pkg::KIND_VOLT:   volt_d   = word;
              sspp_pkg::KIND_CURR:   curr_d   = word;
              sspp_pkg::KIND_CHARGE: charge_d = word;
              sspp_pkg::KIND_CAP:    cap_d    = word;
              default:               ;
            endcase
          end else if (kind_q == sspp_pkg::KIND_CHRG_STATE && rem_q == sspp_pkg::LEN_ONE) begin
            chrg_d = item_i.data_byte;
          end
          rem_d = rem_q - sspp_pkg::RemW'(1);
        end
      end
      if (item_i.last_byte) begin
        ok       = !err_d && (rem_d == '0);
        cleaning = $signed(curr_d) < clean_thr_i;
        docked   = !cleaning && ($signed(curr_d) > dock_thr_i);
        out_valid_d = 1'b1;
        res_d       = '0;
        if (ok) begin
          res_d.packet_ok      = 1'b1;
          res_d.distance_mm    = dist_d;
          res_d.charging_state = chrg_d;
          res_d.voltage_mv     = volt_d;
          res_d.current_ma     = curr_d;
          res_d.charge_mah     = charge_d;
          res_d.capacity_mah   = cap_d;
          res_d.is_cleaning    = cleaning;
          res_d.is_docked      = docked;
        end
        rem_d    = '0;
        kind_d   = sspp_pkg::KIND_SKIP;
        hi_d     = '0;
        err_d    = 1'b0;
        dist_d   = '0;
        chrg_d   = '0;
        volt_d   = '0;
        curr_d   = '0;
        charge_d = '0;
        cap_d    = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q       <= '0;
      kind_q      <= sspp_pkg::KIND_SKIP;
      hi_q        <= '0;
      err_q       <= 1'b0;
      dist_q      <= '0;
      chrg_q      <= '0;
      volt_q      <= '0;
      curr_q      <= '0;
      charge_q    <= '0;
      cap_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      rem_q       <= rem_d;
      kind_q      <= kind_d;
      hi_q        <= hi_d;
      err_q       <= err_d;
      dist_q      <= dist_d;
      chrg_q      <= chrg_d;
      volt_q      <= volt_d;
      curr_q      <= curr_d;
      charge_q    <= charge_d;
      cap_q       <= cap_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.packet_ok      = res_q.packet_ok;
  assign out_o.distance_mm    = res_q.distance_mm;
  assign out_o.charging_state = res_q.charging_state;
  assign out_o.voltage_mv     = res_q.voltage_mv;
  assign out_o.current_ma     = res_q.current_ma;
  assign out_o.charge_mah     = res_q.charge_mah;
  assign out_o.capacity_mah   = res_q.capacity_mah;
  assign out_o.is_cleaning    = res_q.is_cleaning;
  assign out_o.is_docked      = res_q.is_docked;

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && item_i.last_byte) |=> (rem_q == '0) && !err_q && (curr_q == '0))
    else $error("parse state not cleared after last byte");

  a_bad_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !res_q.packet_ok) |->
      (res_q.distance_mm == '0) && (res_q.current_ma == '0) &&
      !res_q.is_cleaning && !res_q.is_docked)
    else $error("bad packet carries nonzero fields");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(res_q.is_cleaning && res_q.is_docked))
    else $error("cleaning and docked both set");

endmodule

// File: src/sensor_stream_packet_parser.sv
// Sensor stream packet parser, top level: config registers, front decoder, queue, back parser.
// Depends on sspp_pkg, sspp_if, sspp_front, sspp_fifo and sspp_back.
//
// Usage: in_i carries one packet byte per request, with last_byte set on the final byte.
// Each byte not inside an open field is a sensor ID; its length decides how many data bytes
// follow. One result request leaves on out_o for every last byte and none otherwise.
// cfg_i writes the cleaning threshold (index 0) and docked threshold (index 1); other
// indexes are dropped. cfg_i is always ready.
// Throughput: one byte per cycle unless a waiting result on out_o holds the flow (see Stall),
// set by the parse step in the back parser. Path: with the queue empty, an accepted last byte
// is first written into the queue; the back parser then takes it and moves its result into
// the output register, from which out_o presents it.
// Reset: parse state and captured values clear, thresholds return to -400 and -50 mA.
// Stall: a waiting result holds in the output register; bytes keep flowing until the next
// last byte reaches the parser, then the queue fills and in_i.ready drops.
module sensor_stream_packet_parser #(
  parameter int unsigned FifoDepth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sspp_in_if.sink    in_i,
  sspp_out_if.source out_o,
  sspp_cfg_if.sink   cfg_i
);

  logic signed [15:0] clean_thr_q;
  logic signed [15:0] dock_thr_q;

  logic            push;
  logic            full;
  logic            pop;
  logic            q_valid;
  sspp_pkg::item_t front_item;
  sspp_pkg::item_t q_item;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clean_thr_q <= sspp_pkg::CLEAN_THR_RESET;
      dock_thr_q  <= sspp_pkg::DOCK_THR_RESET;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == sspp_pkg::CFG_IDX_CLEAN_THR) begin
        clean_thr_q <= $signed(cfg_i.data[15:0]);
      end else if (cfg_i.index == sspp_pkg::CFG_IDX_DOCK_THR) begin
        dock_thr_q <= $signed(cfg_i.data[15:0]);
      end
    end
  end

  sspp_front u_front (
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .item_o (front_item)
  );

  sspp_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  sspp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (q_valid),
    .item_i      (q_item),
    .pop_o       (pop),
    .clean_thr_i (clean_thr_q),
    .dock_thr_i  (dock_thr_q),
    .out_o       (out_o)
  );

endmodule

// File: tb/sv/sspp_report_checker.sv
`timescale 1ns / 100ps
// Report checker for the sensor stream packet parser: watches the byte, result and config
// channels, predicts each packet report and compares it field by field. Needs sspp_pkg, sspp_if.
module sspp_report_checker (
  input  logic clk_i,
  input  logic rst_ni,
  sspp_in_if   in_mon_i,
  sspp_out_if  out_mon_i,
  sspp_cfg_if  cfg_mon_i,
  output int   fail_count_o,
  output int   pending_o,
  output int   reports_o,
  output int   bad_reports_o
);

  localparam int MaxShown = 10;

  logic signed [15:0] clean_thr;
  logic signed [15:0] dock_thr;

  logic [sspp_pkg::RemW-1:0] left_in_field;
  logic [7:0]                field_id;
  logic [7:0]                high_hold;
  logic                      pkt_bad;
  logic signed [15:0]        dist_cap;
  logic [7:0]                chrg_cap;
  logic [15:0]               volt_cap;
  logic signed [15:0]        curr_cap;
  logic signed [15:0]        chg_cap;
  logic [15:0]               cap_cap;

  sspp_pkg::result_t reports_due[$];
  int      mismatches    = 0;
  int      reports_seen  = 0;
  int      bad_seen      = 0;

  task automatic clear_packet();
    left_in_field = '0;
    field_id      = '0;
    high_hold     = '0;
    pkt_bad       = 1'b0;
    dist_cap      = '0;
    chrg_cap      = '0;
    volt_cap      = '0;
    curr_cap      = '0;
    chg_cap       = '0;
    cap_cap       = '0;
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic fin);
    sspp_pkg::result_t rpt;
    logic    is_word;
    is_word = field_id inside {sspp_pkg::ID_DISTANCE, sspp_pkg::ID_VOLTAGE,
                               sspp_pkg::ID_CURRENT, sspp_pkg::ID_CHARGE,
                               sspp_pkg::ID_CAPACITY};
    if (!pkt_bad) begin
      if (left_in_field == '0) begin
        field_id = b;
        case (b)
          sspp_pkg::ID_GROUP_ALL:   left_in_field = sspp_pkg::LEN_GROUP_ALL;
          sspp_pkg::ID_GROUP_BASIC: left_in_field = sspp_pkg::LEN_GROUP_BASIC;
          sspp_pkg::ID_BUMPS, sspp_pkg::ID_VWALL, sspp_pkg::ID_CHRG_STATE,
          sspp_pkg::ID_EXT: left_in_field = sspp_pkg::LEN_ONE;
          sspp_pkg::ID_DISTANCE, sspp_pkg::ID_VOLTAGE, sspp_pkg::ID_CURRENT,
          sspp_pkg::ID_CHARGE, sspp_pkg::ID_CAPACITY: left_in_field = sspp_pkg::LEN_TWO;
          default: begin
            pkt_bad       = 1'b1;
            left_in_field = '0;
          end
        endcase
      end else begin
        if (is_word && left_in_field == sspp_pkg::LEN_TWO) begin
          high_hold = b;
        end else if (is_word && left_in_field == sspp_pkg::LEN_ONE) begin
          case (field_id)
            sspp_pkg::ID_DISTANCE: dist_cap = {high_hold, b};
            sspp_pkg::ID_VOLTAGE:  volt_cap = {high_hold, b};
            sspp_pkg::ID_CURRENT:  curr_cap = {high_hold, b};
            sspp_pkg::ID_CHARGE:   chg_cap  = {high_hold, b};
            default:               cap_cap  = {high_hold, b};
          endcase
        end else if (field_id == sspp_pkg::ID_CHRG_STATE &&
                     left_in_field == sspp_pkg::LEN_ONE) begin
          chrg_cap = b;
        end
        left_in_field = left_in_field - 1'b1;
      end
    end
    if (fin) begin
      rpt = '0;
      if (!pkt_bad && left_in_field == '0) begin
        rpt.packet_ok      = 1'b1;
        rpt.distance_mm    = dist_cap;
        rpt.charging_state = chrg_cap;
        rpt.voltage_mv     = volt_cap;
        rpt.current_ma     = curr_cap;
        rpt.charge_mah     = chg_cap;
        rpt.capacity_mah   = cap_cap;
        rpt.is_cleaning    = curr_cap < clean_thr;
        rpt.is_docked      = !rpt.is_cleaning && (curr_cap > dock_thr);
      end
      reports_due.push_back(rpt);
      clear_packet();
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= MaxShown) begin
        $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      end
    end
  endtask

  task automatic check_report();
    sspp_pkg::result_t due;
    if (reports_due.size() == 0) begin
      mismatches++;
      if (mismatches <= MaxShown) begin
        $display("%0t: report request with no packet pending", $time);
      end
    end else begin
      due = reports_due.pop_front();
      reports_seen++;
      if (!due.packet_ok) bad_seen++;
      check_field("packet_ok", due.packet_ok, out_mon_i.packet_ok);
      check_field("distance_mm", due.distance_mm, out_mon_i.distance_mm);
      check_field("charging_state", due.charging_state, out_mon_i.charging_state);
      check_field("voltage_mv", due.voltage_mv, out_mon_i.voltage_mv);
      check_field("current_ma", due.current_ma, out_mon_i.current_ma);
      check_field("charge_mah", due.charge_mah, out_mon_i.charge_mah);
      check_field("capacity_mah", due.capacity_mah, out_mon_i.capacity_mah);
      check_field("is_cleaning", due.is_cleaning, out_mon_i.is_cleaning);
      check_field("is_docked", due.is_docked, out_mon_i.is_docked);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_packet();
      clean_thr = sspp_pkg::CLEAN_THR_RESET;
      dock_thr  = sspp_pkg::DOCK_THR_RESET;
      reports_due.delete();
    end else begin
      if (out_mon_i.valid && out_mon_i.ready) check_report();
      if (cfg_mon_i.valid && cfg_mon_i.ready) begin
        case (cfg_mon_i.index)
          sspp_pkg::CFG_IDX_CLEAN_THR: clean_thr = cfg_mon_i.data;
          sspp_pkg::CFG_IDX_DOCK_THR:  dock_thr  = cfg_mon_i.data;
          default: ;
        endcase
      end
      if (in_mon_i.valid && in_mon_i.ready) parse_byte(in_mon_i.data_byte, in_mon_i.last_byte);
    end
    fail_count_o  = mismatches;
    pending_o     = reports_due.size();
    reports_o     = reports_seen;
    bad_reports_o = bad_seen;
  end

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps
// Top of the sensor stream packet parser testbench: clock, reset, packet stimulus, threshold
// writes and the verdict. Needs sspp_pkg, sspp_if, the parser RTL and sspp_report_checker.
module testbench;

  localparam int          PhaseBytes   = 170;
  localparam int          NumPhases    = 6;
  localparam int          HoldCycles   = 400;
  localparam int          SettleCycles = 6;
  localparam int          RunLimitNs   = 2_000_000;
  localparam logic [7:0]  ID_UNKNOWN   = 8'hFF;

  logic clk_i;
  logic rst_ni = 1'b0;

  sspp_in_if  in_bus ();
  sspp_out_if out_bus ();
  sspp_cfg_if cfg_bus ();

  int fail_count;
  int pending_reports;
  int reports_seen;
  int bad_seen;

  logic [7:0]  pkt_bytes[$];
  logic [15:0] clean_thr = sspp_pkg::CLEAN_THR_RESET;
  logic [15:0] dock_thr  = sspp_pkg::DOCK_THR_RESET;
  bit          gaps_on   = 1'b0;
  bit          sink_hold = 1'b0;
  int          bytes_sent = 0;
  int          packets    = 0;
  int          settings   = 1;

  sensor_stream_packet_parser dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus),
    .cfg_i  (cfg_bus)
  );

  sspp_report_checker checker_u (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_mon_i      (in_bus),
    .out_mon_i     (out_bus),
    .cfg_mon_i     (cfg_bus),
    .fail_count_o  (fail_count),
    .pending_o     (pending_reports),
    .reports_o     (reports_seen),
    .bad_reports_o (bad_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #(RunLimitNs);
    $display("Test completed with failures");
    $finish;
  end

  // result sink: random stalls, plus one long hold on request
  initial begin
    out_bus.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (sink_hold) begin
        out_bus.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        sink_hold = 1'b0;
      end else if (gaps_on && $urandom_range(0, 7) == 0) begin
        out_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end else begin
        out_bus.ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  function automatic int field_len(input logic [7:0] id);
    case (id)
      sspp_pkg::ID_GROUP_ALL:   return int'(sspp_pkg::LEN_GROUP_ALL);
      sspp_pkg::ID_GROUP_BASIC: return int'(sspp_pkg::LEN_GROUP_BASIC);
      sspp_pkg::ID_BUMPS, sspp_pkg::ID_VWALL, sspp_pkg::ID_CHRG_STATE,
      sspp_pkg::ID_EXT: return int'(sspp_pkg::LEN_ONE);
      sspp_pkg::ID_DISTANCE, sspp_pkg::ID_VOLTAGE, sspp_pkg::ID_CURRENT,
      sspp_pkg::ID_CHARGE, sspp_pkg::ID_CAPACITY: return int'(sspp_pkg::LEN_TWO);
      default: return -1;
    endcase
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h80;
      3:       return 8'h7F;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic fin);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    in_bus.valid     <= 1'b1;
    in_bus.data_byte <= b;
    in_bus.last_byte <= fin;
    do @(posedge clk_i); while (!in_bus.ready);
    bytes_sent++;
  endtask

  task automatic send_pkt_bytes(input bit allow_gaps);
    gaps_on = allow_gaps && ($urandom_range(0, 3) != 0);
    foreach (pkt_bytes[i]) send_byte(pkt_bytes[i], i == pkt_bytes.size() - 1);
    packets++;
  endtask

  task automatic add_field();
    logic [7:0]  id;
    logic [15:0] word;
    case ($urandom_range(0, 19))
      0:          id = sspp_pkg::ID_GROUP_ALL;
      1, 2:       id = sspp_pkg::ID_GROUP_BASIC;
      3:          id = sspp_pkg::ID_BUMPS;
      4:          id = sspp_pkg::ID_VWALL;
      5:          id = sspp_pkg::ID_EXT;
      6, 7:       id = sspp_pkg::ID_DISTANCE;
      8, 9:       id = sspp_pkg::ID_CHRG_STATE;
      10, 11:     id = sspp_pkg::ID_VOLTAGE;
      12, 13, 14: id = sspp_pkg::ID_CURRENT;
      15, 16:     id = sspp_pkg::ID_CHARGE;
      default:    id = sspp_pkg::ID_CAPACITY;
    endcase
    pkt_bytes.push_back(id);
    if (id == sspp_pkg::ID_CURRENT && $urandom_range(0, 2) == 0) begin
      // land on or next to a threshold
      word = ($urandom_range(0, 1) ? clean_thr : dock_thr) - 16'd1 + 16'($urandom_range(0, 2));
      pkt_bytes.push_back(word[15:8]);
      pkt_bytes.push_back(word[7:0]);
    end else begin
      repeat (field_len(id)) pkt_bytes.push_back(pick_byte());
    end
  endtask

  task automatic send_packet(input bit allow_gaps);
    logic [7:0] id;
    int         shape;
    int         cut;
    pkt_bytes.delete();
    shape = $urandom_range(0, 19);
    if (shape <= 2) begin
      repeat ($urandom_range(1, 4)) add_field();
      cut = $urandom_range(1, pkt_bytes.size() - 1);
      while (pkt_bytes.size() > cut) void'(pkt_bytes.pop_back());
    end else if (shape <= 4) begin
      repeat ($urandom_range(0, 2)) add_field();
      do id = 8'($urandom); while (field_len(id) >= 0);
      pkt_bytes.push_back(id);
      repeat ($urandom_range(0, 4)) pkt_bytes.push_back(pick_byte());
    end else if (shape == 5) begin
      repeat ($urandom_range(1, 6)) pkt_bytes.push_back(pick_byte());
    end else begin
      repeat ($urandom_range(1, 5)) add_field();
    end
    send_pkt_bytes(allow_gaps);
  endtask

  task automatic drain();
    in_bus.valid <= 1'b0;
    do @(posedge clk_i); while (pending_reports != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic cfg_put(input logic [sspp_pkg::CfgIdxW-1:0] idx,
                         input logic [sspp_pkg::CfgW-1:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk_i); while (!cfg_bus.ready);
  endtask

  task automatic set_thresholds(input logic [15:0] c, input logic [15:0] d, input bit stray);
    drain();
    cfg_put(sspp_pkg::CFG_IDX_CLEAN_THR, c);
    if (stray) begin
      cfg_put(sspp_pkg::CfgIdxW'($urandom_range(int'(sspp_pkg::CFG_IDX_DOCK_THR) + 1,
                                                (1 << sspp_pkg::CfgIdxW) - 1)),
              sspp_pkg::CfgW'($urandom));
    end
    cfg_put(sspp_pkg::CFG_IDX_DOCK_THR, d);
    cfg_bus.valid <= 1'b0;
    clean_thr = c;
    dock_thr  = d;
    settings++;
  endtask

  initial begin
    int target;
    in_bus.valid     <= 1'b0;
    in_bus.data_byte <= '0;
    in_bus.last_byte <= 1'b0;
    cfg_bus.valid    <= 1'b0;
    cfg_bus.index    <= '0;
    cfg_bus.data     <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    pkt_bytes = '{sspp_pkg::ID_CURRENT, 8'h80, 8'h00};
    send_pkt_bytes(1'b1);
    pkt_bytes = '{sspp_pkg::ID_DISTANCE, 8'h7F, 8'hFF, sspp_pkg::ID_CHRG_STATE, 8'hFF,
                  sspp_pkg::ID_VOLTAGE, 8'hFF, 8'hFF, sspp_pkg::ID_EXT, 8'hAA};
    send_pkt_bytes(1'b1);
    pkt_bytes = '{sspp_pkg::ID_CHARGE, 8'h80, 8'h00, sspp_pkg::ID_CAPACITY, 8'hFF, 8'hFF,
                  sspp_pkg::ID_BUMPS, 8'h55, sspp_pkg::ID_CURRENT, 8'h7F, 8'hFF};
    send_pkt_bytes(1'b1);
    pkt_bytes = '{ID_UNKNOWN, sspp_pkg::ID_GROUP_ALL};
    send_pkt_bytes(1'b1);
    pkt_bytes = '{sspp_pkg::ID_VOLTAGE};
    send_pkt_bytes(1'b1);
    pkt_bytes = '{sspp_pkg::ID_CURRENT, 8'h12};
    send_pkt_bytes(1'b1);

    for (int phase = 0; phase < NumPhases; phase++) begin
      case (phase)
        1: set_thresholds(16'h8000, 16'h7FFF, 1'b0);
        2: set_thresholds(16'h7FFF, 16'h8000, 1'b1);
        3: set_thresholds(16'h0000, 16'h0000, 1'b0);
        4: set_thresholds(16'($urandom), 16'($urandom), 1'b1);
        5: set_thresholds(sspp_pkg::CLEAN_THR_RESET, sspp_pkg::DOCK_THR_RESET, 1'b0);
        default: ;
      endcase
      // hold the result side off while bytes keep coming
      if (phase == 2) sink_hold = 1'b1;
      target = bytes_sent + PhaseBytes;
      while (bytes_sent < target) send_packet(phase != NumPhases - 1);
    end
    gaps_on = 1'b0;
    drain();

    $display("Sent %0d bytes in %0d packets under %0d threshold settings.",
             bytes_sent, packets, settings);
    $display("Checked %0d reports, %0d of them bad packets.", reports_seen, bad_seen);
    if (fail_count == 0 && pending_reports == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
